FILE: hw/rtl/swdhte_pkg.sv
// ----------------------------------------------------------------------------
// swdhte_pkg: shared types and constants of the SWD host engine
// Item payload structs, mode and status codes, protocol constants.
// ----------------------------------------------------------------------------
package swdhte_pkg;

  localparam int DATA_BITS    = 32;
  localparam int REQUEST_BITS = 7;

  // Command modes carried by an input item
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_READ  = 3'd1;
  localparam logic [2:0] MODE_WRITE = 3'd2;
  localparam logic [2:0] MODE_TSEL  = 3'd3;
  localparam logic [2:0] MODE_RAW   = 3'd4;

  // Command kind held while a command runs; idle uses the tick code
  localparam logic [2:0] KIND_IDLE  = MODE_TICK;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NACK   = 2'd1;
  localparam logic [1:0] ST_PARITY = 2'd2;
  localparam logic [1:0] ST_BUSY   = 2'd3;

  localparam logic [2:0] ACK_OK        = 3'b001;
  localparam logic [6:0] TSEL_REQUEST  = 7'h19;  // low 7 bits of 0x99
  localparam int         TSEL_SHIFT    = 28;
  localparam logic [5:0] TSEL_UNDRIVEN = 6'(1 + 5);
  localparam logic [5:0] RAW_MAX       = 6'(DATA_BITS);

  // Configuration register addresses
  localparam logic [1:0] ADDR_TURNAROUND = 2'd0;
  localparam logic [2:0] TURN_RESET      = 3'd1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  request;
    logic [31:0] write_data;
    logic [5:0]  bit_count;
    logic [3:0]  target_instance;
    logic        line_sample;
  } swd_in_t;

  typedef struct packed {
    logic        clock_pulse;
    logic        drive_level;
    logic        drive_enable;
    logic        done_res;
    logic [1:0]  status;
    logic [2:0]  ack_value;
    logic [31:0] read_data;
  } swd_out_t;

endpackage

FILE: hw/rtl/swdhte_regs.sv
// ----------------------------------------------------------------------------
// swdhte_regs: configuration register file
// APB-style slave holding the turnaround length register.
// ----------------------------------------------------------------------------
module swdhte_regs import swdhte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [2:0]  turn_bits
);

  logic [2:0] turn_r;
  logic [2:0] turn_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == ADDR_TURNAROUND);

  always_comb begin
    turn_nxt = turn_r;
    if (wr_en) begin
      turn_nxt = pwdata[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_r <= TURN_RESET;
    end else begin
      turn_r <= turn_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_TURNAROUND) begin
      prdata = {29'd0, turn_r};
    end
  end

  assign turn_bits = turn_r;

  // Register changes only through a write to its own address
  a_turn_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !wr_en |=> $stable(turn_r))
    else $error("turnaround register changed without a write");

endmodule

FILE: hw/rtl/swdhte_core.sv
// ----------------------------------------------------------------------------
// swdhte_core: SWD bit sequencer
// Phase machine and shift registers; one input item is one step.
// ----------------------------------------------------------------------------
module swdhte_core import swdhte_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  swd_in_t  item,
  input  logic [2:0] turn_bits,
  output swd_out_t res
);

  typedef enum logic [10:0] {
    P_IDLE  = 11'b000_0000_0001,
    P_REQ   = 11'b000_0000_0010,
    P_PARK  = 11'b000_0000_0100,
    P_ACK   = 11'b000_0000_1000,
    P_TURNA = 11'b000_0001_0000,
    P_RDATA = 11'b000_0010_0000,
    P_RPAR  = 11'b000_0100_0000,
    P_TURNE = 11'b000_1000_0000,
    P_WDATA = 11'b001_0000_0000,
    P_WPAR  = 11'b010_0000_0000,
    P_RAW   = 11'b100_0000_0000
  } phase_t;

  phase_t      phase_r,     phase_nxt;
  logic [2:0]  kind_r,      kind_nxt;
  logic [5:0]  bits_r,      bits_nxt;
  logic [6:0]  req_r,       req_nxt;
  logic [31:0] data_r,      data_nxt;
  logic [2:0]  ack_r,       ack_nxt;
  logic        par_r,       par_nxt;

  logic        is_start;
  logic        finish;
  logic [5:0]  bits_dec;
  logic [2:0]  turn_len;
  logic [5:0]  raw_cnt;

  // Clamp the turnaround register into 1..4
  always_comb begin
    turn_len = turn_bits;
    if (turn_bits == 3'd0) begin
      turn_len = 3'd1;
    end else if (turn_bits > 3'd4) begin
      turn_len = 3'd4;
    end
  end

  assign is_start = item.mode inside {[MODE_READ:MODE_RAW]};
  assign bits_dec = bits_r - 6'd1;
  assign raw_cnt  = (item.bit_count > RAW_MAX) ? RAW_MAX : item.bit_count;

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    bits_nxt  = bits_r;
    req_nxt   = req_r;
    data_nxt  = data_r;
    ack_nxt   = ack_r;
    par_nxt   = par_r;
    res       = '0;
    finish    = 1'b0;

    if (is_start) begin
      if (phase_r != P_IDLE) begin
        res.status = ST_BUSY;
      end else begin
        kind_nxt = item.mode;
        ack_nxt  = '0;
        par_nxt  = 1'b0;
        if (item.mode == MODE_RAW) begin
          data_nxt = item.write_data;
          if (raw_cnt == 6'd0) begin
            kind_nxt     = KIND_IDLE;
            bits_nxt     = '0;
            res.done_res = 1'b1;
          end else begin
            phase_nxt = P_RAW;
            bits_nxt  = raw_cnt;
          end
        end else begin
          req_nxt   = (item.mode == MODE_TSEL) ? TSEL_REQUEST : item.request[6:0];
          data_nxt  = item.write_data;
          if (item.mode == MODE_TSEL) begin
            data_nxt = item.write_data | (32'(item.target_instance) << TSEL_SHIFT);
          end else if (item.mode == MODE_READ) begin
            data_nxt = '0;
          end
          phase_nxt = P_REQ;
          bits_nxt  = 6'(REQUEST_BITS);
        end
      end
    end else if (phase_r != P_IDLE) begin
      res.clock_pulse = 1'b1;
      case (phase_r)
        P_REQ: begin
          res.drive_enable = 1'b1;
          res.drive_level  = req_r[0];
          req_nxt  = {1'b0, req_r[6:1]};
          bits_nxt = bits_dec;
          if (bits_dec == 6'd0) begin
            phase_nxt = P_PARK;
            bits_nxt  = (kind_r == MODE_TSEL) ? TSEL_UNDRIVEN : 6'd1 + 6'(turn_len);
          end
        end
        P_PARK: begin
          bits_nxt = bits_dec;
          if (bits_dec == 6'd0) begin
            if (kind_r == MODE_TSEL) begin
              phase_nxt = P_WDATA;
              bits_nxt  = 6'(DATA_BITS);
            end else begin
              phase_nxt = P_ACK;
              bits_nxt  = 6'd3;
            end
          end
        end
        P_ACK: begin
          ack_nxt  = {item.line_sample, ack_r[2:1]};
          bits_nxt = bits_dec;
          if (bits_dec == 6'd0) begin
            if (kind_r == MODE_READ && ack_nxt == ACK_OK) begin
              phase_nxt = P_RDATA;
              bits_nxt  = 6'(DATA_BITS);
            end else begin
              phase_nxt = P_TURNA;
              bits_nxt  = 6'(turn_len);
            end
          end
        end
        P_TURNA: begin
          bits_nxt = bits_dec;
          if (bits_dec == 6'd0) begin
            if (ack_r != ACK_OK || kind_r != MODE_WRITE) begin
              res.status = ST_NACK;
              finish     = 1'b1;
            end else begin
              phase_nxt = P_WDATA;
              bits_nxt  = 6'(DATA_BITS);
            end
          end
        end
        P_RDATA: begin
          data_nxt = {item.line_sample, data_r[31:1]};
          par_nxt  = par_r ^ item.line_sample;
          bits_nxt = bits_dec;
          if (bits_dec == 6'd0) begin
            phase_nxt = P_RPAR;
          end
        end
        P_RPAR: begin
          par_nxt   = par_r ^ item.line_sample;
          phase_nxt = P_TURNE;
          bits_nxt  = 6'(turn_len);
        end
        P_TURNE: begin
          bits_nxt = bits_dec;
          if (bits_dec == 6'd0) begin
            finish = 1'b1;
            if (par_r) begin
              res.status = ST_PARITY;
            end else begin
              res.read_data = data_r;
            end
          end
        end
        P_WDATA: begin
          res.drive_enable = 1'b1;
          res.drive_level  = data_r[0];
          par_nxt  = par_r ^ data_r[0];
          data_nxt = {1'b0, data_r[31:1]};
          bits_nxt = bits_dec;
          if (bits_dec == 6'd0) begin
            phase_nxt = P_WPAR;
          end
        end
        P_WPAR: begin
          res.drive_enable = 1'b1;
          res.drive_level  = par_r;
          finish = 1'b1;
        end
        P_RAW: begin
          res.drive_enable = 1'b1;
          res.drive_level  = data_r[0];
          data_nxt = {1'b0, data_r[31:1]};
          bits_nxt = bits_dec;
          if (bits_dec == 6'd0) begin
            finish = 1'b1;
          end
        end
        default: begin
          res.clock_pulse = 1'b0;
          phase_nxt = P_IDLE;
          kind_nxt  = KIND_IDLE;
          bits_nxt  = '0;
        end
      endcase
      if (finish) begin
        res.done_res = 1'b1;
        if (kind_r == MODE_READ || kind_r == MODE_WRITE) begin
          res.ack_value = ack_nxt;
        end
        phase_nxt = P_IDLE;
        kind_nxt  = KIND_IDLE;
        bits_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      kind_r  <= KIND_IDLE;
      bits_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      bits_r  <= bits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      req_r  <= req_nxt;
      data_r <= data_nxt;
      ack_r  <= ack_nxt;
      par_r  <= par_nxt;
    end
  end

  // Idle phase always pairs with the idle kind
  a_idle_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == P_IDLE) |-> (kind_r == KIND_IDLE))
    else $error("idle phase with a command kind set");

  // A rejected command leaves the running one untouched
  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (step && is_start && phase_r != P_IDLE) |=>
      ($stable(phase_r) && $stable(bits_r) && $stable(data_r)))
    else $error("busy reject advanced the running command");

  // Request phase counts within the request length
  a_req_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == P_REQ) |-> (bits_r != 6'd0 && bits_r <= 6'(REQUEST_BITS)))
    else $error("request bit count out of range");

endmodule

FILE: hw/rtl/swd_host_transaction_engine.sv
// ----------------------------------------------------------------------------
// swd_host_transaction_engine: Serial Wire Debug host bit engine
// Runs read, write, target-select and raw-send commands one bit per item.
// ----------------------------------------------------------------------------
//
//   channel  | ports                                 | direction
//   ---------+---------------------------------------+----------
//   input    | in_valid, in_stall, in_data           | to block
//   result   | out_valid, out_stall, out_data        | from block
//   config   | psel, penable, pwrite, paddr, pwdata, | APB slave
//            | prdata, pready                        |
//
// Every item passes through the sequencer: an item sits in the input
// register, the phase logic works on it in one pass and its result lands in
// the output register, so the block sustains one item per clock while
// out_stall stays low. A result passes through the input register and then
// the output register before it shows on out_valid.
// rst_n is synchronous, active low; it idles the sequencer and empties both
// registers. The turnaround register resets to 1.
// A stalled result holds the output register; the input register then holds
// its item and in_stall rises, so a new item waits upstream.
//
module swd_host_transaction_engine import swdhte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  swd_in_t     in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output swd_out_t    out_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       in_valid_r, in_valid_nxt;
  swd_in_t    in_hold_r;
  logic       out_valid_r, out_valid_nxt;
  swd_out_t   out_data_r;
  swd_out_t   step_res;
  logic       step;
  logic       in_take;
  logic [2:0] turn_bits;

  // Work on the held item whenever the output register is free or emptying
  assign step     = in_valid_r && (!out_valid_r || !out_stall);
  // Hold the input register while its item cannot move on
  assign in_stall = in_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture on acceptance and on a sequencer step
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_hold_r <= in_data;
    end
    if (step) begin
      out_data_r <= step_res;
    end
  end

  swdhte_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .turn_bits (turn_bits)
  );

  swdhte_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (in_hold_r),
    .turn_bits (turn_bits),
    .res       (step_res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A step always fills the output register on the next clock
  a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("stepped item produced no result");

endmodule

FILE: tb/swd_engine_checker.sv
// ----------------------------------------------------------------------------
// swd_engine_checker: scoreboard for the SWD host bit engine
// Watches the item, result and APB ports, predicts every result and
// compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module swd_engine_checker import swdhte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  swd_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  swd_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  output int          pending,
  output int          fail_count
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_REQUEST, PH_PARK, PH_ACK, PH_TURN_ACK, PH_READ_DATA,
    PH_READ_PARITY, PH_TURN_END, PH_WRITE_DATA, PH_WRITE_PARITY, PH_RAW
  } seq_phase_t;

  logic [2:0]  turn_reg;
  logic [2:0]  seq_kind;
  seq_phase_t  seq_phase;
  logic [5:0]  bits_to_go;
  logic [7:0]  req_bits;
  logic [31:0] data_bits;
  logic [2:0]  ack_bits;
  logic        parity_bit;

  swd_out_t    expected_q[$];

  initial fail_count = 0;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // 0 counts as 1 and anything above 4 as 4
  function automatic logic [5:0] turnaround_len();
    if (turn_reg == 3'd0) return 6'd1;
    if (turn_reg > 3'd4) return 6'd4;
    return {3'b000, turn_reg};
  endfunction

  function automatic void go_idle();
    seq_kind   = KIND_IDLE;
    seq_phase  = PH_IDLE;
    bits_to_go = '0;
  endfunction

  // Advance the engine by one item and return the result it yields
  function automatic swd_out_t engine_step(input swd_in_t it);
    swd_out_t   r;
    logic       finish;
    logic [5:0] count;
    r = '0;
    finish = 1'b0;
    if (it.mode >= MODE_READ && it.mode <= MODE_RAW) begin
      if (seq_phase != PH_IDLE) begin
        r.status = ST_BUSY;
      end else begin
        seq_kind   = it.mode;
        ack_bits   = '0;
        parity_bit = 1'b0;
        if (it.mode == MODE_RAW) begin
          count = (it.bit_count > RAW_MAX) ? RAW_MAX : it.bit_count;
          data_bits = it.write_data;
          if (count == '0) begin
            go_idle();
            r.done_res = 1'b1;
          end else begin
            seq_phase  = PH_RAW;
            bits_to_go = count;
          end
        end else begin
          req_bits = (it.mode == MODE_TSEL) ? {1'b1, TSEL_REQUEST} : it.request;
          if (it.mode == MODE_TSEL)
            data_bits = it.write_data | (32'(it.target_instance) << TSEL_SHIFT);
          else if (it.mode == MODE_READ)
            data_bits = '0;
          else
            data_bits = it.write_data;
          seq_phase  = PH_REQUEST;
          bits_to_go = 6'(REQUEST_BITS);
        end
      end
    end else if (seq_phase != PH_IDLE) begin
      r.clock_pulse = 1'b1;
      case (seq_phase)
        PH_REQUEST: begin
          r.drive_enable = 1'b1;
          r.drive_level  = req_bits[0];
          req_bits       = req_bits >> 1;
          bits_to_go     = bits_to_go - 6'd1;
          if (bits_to_go == '0) begin
            seq_phase  = PH_PARK;
            bits_to_go = (seq_kind == MODE_TSEL) ? TSEL_UNDRIVEN : 6'd1 + turnaround_len();
          end
        end
        PH_PARK: begin
          bits_to_go = bits_to_go - 6'd1;
          if (bits_to_go == '0) begin
            if (seq_kind == MODE_TSEL) begin
              seq_phase  = PH_WRITE_DATA;
              bits_to_go = 6'(DATA_BITS);
            end else begin
              seq_phase  = PH_ACK;
              bits_to_go = 6'd3;
            end
          end
        end
        PH_ACK: begin
          ack_bits   = {it.line_sample, ack_bits[2:1]};
          bits_to_go = bits_to_go - 6'd1;
          if (bits_to_go == '0) begin
            if (seq_kind == MODE_READ && ack_bits == ACK_OK) begin
              seq_phase  = PH_READ_DATA;
              bits_to_go = 6'(DATA_BITS);
            end else begin
              seq_phase  = PH_TURN_ACK;
              bits_to_go = turnaround_len();
            end
          end
        end
        PH_TURN_ACK: begin
          bits_to_go = bits_to_go - 6'd1;
          if (bits_to_go == '0) begin
            if (ack_bits != ACK_OK || seq_kind != MODE_WRITE) begin
              r.status = ST_NACK;
              finish   = 1'b1;
            end else begin
              seq_phase  = PH_WRITE_DATA;
              bits_to_go = 6'(DATA_BITS);
            end
          end
        end
        PH_READ_DATA: begin
          data_bits  = {it.line_sample, data_bits[31:1]};
          parity_bit = parity_bit ^ it.line_sample;
          bits_to_go = bits_to_go - 6'd1;
          if (bits_to_go == '0) seq_phase = PH_READ_PARITY;
        end
        PH_READ_PARITY: begin
          parity_bit = parity_bit ^ it.line_sample;
          seq_phase  = PH_TURN_END;
          bits_to_go = turnaround_len();
        end
        PH_TURN_END: begin
          bits_to_go = bits_to_go - 6'd1;
          if (bits_to_go == '0) begin
            r.status = parity_bit ? ST_PARITY : ST_OK;
            if (!parity_bit) r.read_data = data_bits;
            finish = 1'b1;
          end
        end
        PH_WRITE_DATA: begin
          r.drive_enable = 1'b1;
          r.drive_level  = data_bits[0];
          parity_bit     = parity_bit ^ data_bits[0];
          data_bits      = data_bits >> 1;
          bits_to_go     = bits_to_go - 6'd1;
          if (bits_to_go == '0) seq_phase = PH_WRITE_PARITY;
        end
        PH_WRITE_PARITY: begin
          r.drive_enable = 1'b1;
          r.drive_level  = parity_bit;
          finish         = 1'b1;
        end
        PH_RAW: begin
          r.drive_enable = 1'b1;
          r.drive_level  = data_bits[0];
          data_bits      = data_bits >> 1;
          if (bits_to_go != '0) bits_to_go = bits_to_go - 6'd1;
          if (bits_to_go == '0) finish = 1'b1;
        end
        default: begin
          go_idle();
          r.clock_pulse = 1'b0;
        end
      endcase
      if (finish) begin
        r.done_res = 1'b1;
        if (seq_kind == MODE_READ || seq_kind == MODE_WRITE) r.ack_value = ack_bits;
        go_idle();
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    swd_out_t want;
    if (!rst_n) begin
      turn_reg   = TURN_RESET;
      go_idle();
      req_bits   = '0;
      data_bits  = '0;
      ack_bits   = '0;
      parity_bit = 1'b0;
      expected_q.delete();
    end else begin
      if (psel && penable && pready && paddr == ADDR_TURNAROUND) begin
        if (pwrite) turn_reg = pwdata[2:0];
        else check_field("turnaround readback", prdata, {29'b0, turn_reg});
      end
      // compare before pushing: an item never yields its result on its own edge
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("result with no item waiting");
        end else begin
          want = expected_q.pop_front();
          check_field("clock_pulse", 32'(out_data.clock_pulse), 32'(want.clock_pulse));
          check_field("drive_level", 32'(out_data.drive_level), 32'(want.drive_level));
          check_field("drive_enable", 32'(out_data.drive_enable), 32'(want.drive_enable));
          check_field("done_res", 32'(out_data.done_res), 32'(want.done_res));
          check_field("status", 32'(out_data.status), 32'(want.status));
          check_field("ack_value", 32'(out_data.ack_value), 32'(want.ack_value));
          check_field("read_data", out_data.read_data, want.read_data);
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(engine_step(in_data));
    end
    pending <= expected_q.size();
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the SWD host bit engine
// Drives well-formed read, write, target-select and raw-send sequences with
// random line levels, mixed with busy commands, unknown modes and broken
// sequences, across several turnaround settings. A separate checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import swdhte_pkg::*;

  localparam int ITEM_GOAL      = 1850;
  localparam int QUIET_AT       = 1600;  // no idling on either side past this
  localparam int HOLD_AT        = 500;   // long receiver hold-off starts here
  localparam int HOLD_CYCLES    = 150;
  localparam int CFG_SPACING    = 220;
  localparam int DRAIN_CYCLES   = 3;     // covers the input and output registers plus margin
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  swd_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  swd_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          pending;
  int          mismatches;
  int          sent_count = 0;
  int          idle_odds = 0;      // 0 means the sender never idles
  int          turn_eff = 1;       // turnaround length the engine will use
  int          idle_cycles = 0;
  logic        quiet;

  assign quiet = (sent_count >= QUIET_AT);

  always #4 clk = ~clk;

  swd_host_transaction_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  swd_engine_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pending   (pending),
    .fail_count(mismatches)
  );

  // Drop the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall bursts in some stretches, one long hold-off so
  // the engine fills and stalls its input, and nothing in the quiet tail.
  initial begin
    bit held_long;
    int cyc;
    held_long = 1'b0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!held_long && sent_count >= HOLD_AT) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && (cyc / 200) % 3 != 0 && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic swd_in_t random_item(input logic [2:0] mode);
    swd_in_t it;
    it.mode            = mode;
    it.request         = 8'($urandom);
    it.write_data      = $urandom;
    it.bit_count       = 6'($urandom);
    it.target_instance = 4'($urandom);
    it.line_sample     = 1'($urandom);
    return it;
  endfunction

  // Mostly a plain tick, sometimes one of the unused codes above raw send
  function automatic logic [2:0] tick_mode();
    if ($urandom_range(0, 9) == 0) return MODE_RAW + 3'($urandom_range(1, 3));
    return MODE_TICK;
  endfunction

  function automatic logic [2:0] start_mode();
    case ($urandom_range(0, 3))
      0:       return MODE_READ;
      1:       return MODE_WRITE;
      2:       return MODE_TSEL;
      default: return MODE_RAW;
    endcase
  endfunction

  // Offer one item, hold it until accepted, then maybe idle for a burst
  task automatic drive_item(input swd_in_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Change the turnaround length on a drained engine and read it back
  task automatic set_turnaround(input logic [2:0] value);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    apb_access(1'b1, ADDR_TURNAROUND, {29'($urandom), value});
    apb_access(1'b0, ADDR_TURNAROUND, '0);
    turn_eff = (value == 3'd0) ? 1 : (value > 3'd4) ? 4 : int'(value);
  endtask

  // Start one command and follow it with the ticks it needs. Line levels are
  // random except the acknowledge and, for reads, the parity bit. Slack
  // shortens or stretches the tick run to break the sequence; noisy mixes in
  // busy starts that the engine must reject.
  task automatic issue_command(input logic [2:0] op, input logic [2:0] ack,
                               input logic par_flip, input logic [5:0] count,
                               input int slack, input bit noisy);
    swd_in_t      it;
    logic [127:0] levels;
    int           ticks;
    int           ack_at;
    logic [31:0]  word;
    it      = random_item(op);
    levels  = {$urandom, $urandom, $urandom, $urandom};
    ack_at  = REQUEST_BITS + 1 + turn_eff;
    ticks   = 0;
    case (op)
      MODE_READ, MODE_WRITE: begin
        levels[ack_at +: 3] = ack;
        ticks = ack_at + 3 + turn_eff;
        if (ack == ACK_OK && op == MODE_READ) begin
          word = levels[ack_at + 3 +: 32];
          levels[ack_at + 3 + DATA_BITS] = ^word ^ par_flip;
          ticks = ack_at + 3 + DATA_BITS + 1 + turn_eff;
        end else if (ack == ACK_OK) begin
          ticks = ticks + DATA_BITS + 1;
        end
      end
      MODE_TSEL: ticks = REQUEST_BITS + int'(TSEL_UNDRIVEN) + DATA_BITS + 1;
      MODE_RAW: begin
        it.bit_count = count;
        ticks = (count > RAW_MAX) ? int'(RAW_MAX) : int'(count);
      end
      default: ticks = 0;
    endcase
    ticks = ticks + slack;
    if (ticks < 0) ticks = 0;
    drive_item(it);
    for (int k = 0; k < ticks; k++) begin
      if (noisy && $urandom_range(0, 24) == 0) drive_item(random_item(start_mode()));
      it = random_item(noisy ? tick_mode() : MODE_TICK);
      it.line_sample = levels[k];
      drive_item(it);
    end
  endtask

  initial begin
    swd_in_t    it;
    logic [2:0] turn_plan [8];
    logic [2:0] op;
    logic [2:0] ack;
    logic [5:0] count;
    int         cfg_idx;
    int         next_cfg_at;
    int         pick;
    int         slack;
    turn_plan = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6, 3'd1};
    cfg_idx = 0;
    next_cfg_at = 0;

    // Hold reset, then release it once
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle tick, unused mode, raw count zero, single raw bit,
    // a busy start during a raw send, then a read that gets a fault ack.
    drive_item(random_item(MODE_TICK));
    drive_item(random_item(MODE_RAW + 3'd3));
    it = random_item(MODE_RAW);
    it.bit_count = '0;
    drive_item(it);
    it = random_item(MODE_RAW);
    it.bit_count  = 6'd1;
    it.write_data = '1;
    drive_item(it);
    drive_item(random_item(MODE_TICK));
    it = random_item(MODE_RAW);
    it.bit_count  = 6'd2;
    it.write_data = '0;
    drive_item(it);
    drive_item(random_item(MODE_READ));
    drive_item(random_item(MODE_TICK));
    drive_item(random_item(MODE_TICK));
    issue_command(MODE_READ, 3'b100, 1'b0, '0, 0, 1'b0);

    // Random: whole commands with random content, reconfigured every few
    // hundred items; each reconfiguration first drains the engine.
    while (sent_count < ITEM_GOAL) begin
      if (cfg_idx < 8 && sent_count >= next_cfg_at) begin
        set_turnaround(turn_plan[cfg_idx]);
        cfg_idx++;
        next_cfg_at += CFG_SPACING;
      end
      case ($urandom_range(0, 2))
        0:       idle_odds = 0;
        1:       idle_odds = 3;
        default: idle_odds = 10;
      endcase
      pick = $urandom_range(0, 99);
      op = (pick < 30) ? MODE_READ : (pick < 55) ? MODE_WRITE :
           (pick < 70) ? MODE_TSEL : MODE_RAW;
      ack = ($urandom_range(0, 3) != 0) ? ACK_OK : 3'($urandom);
      count = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(1, 12));
      slack = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 6) - 3 : 0;
      issue_command(op, ack, 1'($urandom_range(0, 3) == 0), count, slack, 1'b1);
      repeat ($urandom_range(0, 2)) drive_item(random_item(tick_mode()));
    end

    // Let the last results come back, then give the verdict
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
